// ----- design/dtmf_pkg.sv -----
package dtmf_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1,
    CFG_DEPTH_CUTOFF = 8'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned GeoBits     = 11;
  localparam int unsigned DepthBits   = 16;

  localparam logic [GeoBits-1:0]   FrameWidthReset  = 11'd640;
  localparam logic [GeoBits-1:0]   FrameHeightReset = 11'd480;
  localparam logic [DepthBits-1:0] DepthCutoffReset = 16'd216;
  localparam logic [GeoBits-1:0]   GeoMin           = 11'd3;

  localparam int unsigned NumStages = 4;
  // dilate, erode, erode, dilate
  localparam logic [NumStages-1:0] StageErodes = 4'b0110;

  // 3x3 window: bits 0..2 top row, 3..5 middle, 6..8 bottom; new column enters at the right
  localparam logic [8:0] KeepLeftMid = 9'h0DB;
  localparam logic [8:0] RowTop      = 9'h007;
  localparam logic [8:0] RowBottom   = 9'h1C0;
  localparam logic [8:0] ColLeft     = 9'h049;
  localparam logic [8:0] ColRight    = 9'h124;

  // one pipeline slot between stages
  typedef struct packed {
    logic tok;  // an item occupies the slot
    logic vld;  // the item carries a pixel
    logic px;   // mask value
  } tok_t;

endpackage

// ----- design/dtmf_ram.sv -----
module dtmf_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- design/dtmf_stage.sv -----
module dtmf_stage #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter bit          ERODE      = 1'b0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  geo_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] geo_h_i,
  input  dtmf_pkg::tok_t                  in_i,
  output dtmf_pkg::tok_t                  out_o,
  output logic                            last_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] icol_q, icol_d, ocol_q, ocol_d;
  logic [RW-1:0] irow_q, irow_d, orow_q, orow_d;
  logic          tail_on_q, tail_on_d;
  logic [WW-1:0] tail_col_q, tail_col_d;
  logic [8:0]    win_q, win_d;
  dtmf_pkg::tok_t out_q;
  logic          last_q;

  logic       tick, in_valid, emit, res, last;
  logic [1:0] rd_tail, rd_col;

  assign tick     = en_i & in_i.tok;
  assign in_valid = tick & in_i.vld;

  // each entry holds {upper line, lower line} of one column
  dtmf_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i    (clk_i),
    .we_i     (in_valid),
    .waddr_i  (icol_q),
    .wdata_i  ({rd_col[0], in_i.px}),
    .raddr_a_i(tail_col_d[CW-1:0]),
    .rdata_a_o(rd_tail),
    .raddr_b_i(icol_d),
    .rdata_b_o(rd_col)
  );

  always_comb begin
    logic       col_wrap, row_wrap, ocol_end, orow_end, tail_inside, shift;
    logic       top, mid, bot;
    logic [8:0] incl;
    col_wrap    = (WW'(icol_q) + WW'(1)) >= geo_w_i;
    row_wrap    = (HW'(irow_q) + HW'(1)) >= geo_h_i;
    ocol_end    = (WW'(ocol_q) + WW'(1)) >= geo_w_i;
    orow_end    = (HW'(orow_q) + HW'(1)) >= geo_h_i;
    tail_inside = tail_col_q < geo_w_i;

    icol_d     = icol_q;
    irow_d     = irow_q;
    ocol_d     = ocol_q;
    orow_d     = orow_q;
    tail_on_d  = tail_on_q;
    tail_col_d = tail_col_q;
    win_d      = win_q;

    top   = 1'b0;
    mid   = 1'b0;
    bot   = 1'b0;
    shift = 1'b0;
    if (tick && tail_on_q) begin
      // tail of the previous frame reads the old lines at its own column
      shift = 1'b1;
      if (tail_inside) begin
        top = rd_tail[1];
        mid = rd_tail[0];
      end else if (in_valid) begin
        top = rd_col[1];
        mid = rd_col[0];
        bot = in_i.px;
      end
    end else if (in_valid) begin
      shift = 1'b1;
      top   = rd_col[1];
      mid   = rd_col[0];
      bot   = in_i.px;
    end
    if (shift) begin
      win_d = ((win_q >> 1) & dtmf_pkg::KeepLeftMid) | {bot, 2'b00, mid, 2'b00, top, 2'b00};
    end

    emit = tick && (tail_on_q ||
           (in_valid && (irow_q >= RW'(2) || (irow_q == RW'(1) && icol_q != '0))));

    // frame border cells drop out of the window
    incl = 9'h1FF;
    if (orow_q == '0) incl = incl & ~dtmf_pkg::RowTop;
    if (orow_end)     incl = incl & ~dtmf_pkg::RowBottom;
    if (ocol_q == '0) incl = incl & ~dtmf_pkg::ColLeft;
    if (ocol_end)     incl = incl & ~dtmf_pkg::ColRight;
    if (ERODE) begin
      res = (win_d & incl) == incl;
    end else begin
      res = (win_d & incl) != '0;
    end
    last = ocol_end && orow_end;

    if (emit) begin
      if (ocol_end) begin
        ocol_d = '0;
        orow_d = orow_end ? '0 : orow_q + RW'(1);
      end else begin
        ocol_d = ocol_q + CW'(1);
      end
    end

    if (tick && tail_on_q) begin
      if (tail_inside) begin
        tail_col_d = tail_col_q + WW'(1);
      end else begin
        tail_on_d = 1'b0;
      end
    end

    if (in_valid) begin
      if (col_wrap) begin
        icol_d = '0;
        if (row_wrap) begin
          irow_d     = '0;
          tail_on_d  = 1'b1;
          tail_col_d = '0;
        end else begin
          irow_d = irow_q + RW'(1);
        end
      end else begin
        icol_d = icol_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q     <= '0;
      irow_q     <= '0;
      ocol_q     <= '0;
      orow_q     <= '0;
      tail_on_q  <= 1'b0;
      tail_col_q <= '0;
      win_q      <= '0;
      out_q      <= '0;
    end else begin
      icol_q     <= icol_d;
      irow_q     <= irow_d;
      ocol_q     <= ocol_d;
      orow_q     <= orow_d;
      tail_on_q  <= tail_on_d;
      tail_col_q <= tail_col_d;
      win_q      <= win_d;
      if (en_i) begin
        out_q.tok <= in_i.tok;
        out_q.vld <= emit;
        out_q.px  <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q <= last;
    end
  end

  assign out_o  = out_q;
  assign last_o = last_q;

endmodule

// ----- design/depth_threshold_morph_filter.sv -----
// Depth pixels arrive in raster order, one word per cycle while not stalled, and leave as a
// binary mask (depth >= depth_cutoff) after a 3x3 dilate, erode, erode, dilate chain, with
// cells outside the frame left out of each window. The block takes one input word every cycle
// unless the two-word result queue is full. The four stages each hold a line store and sit
// one register apart: a word goes through the input register and each stage output register.
// Each stage delays by frame_width+1 pixels, so the mask of pixel p is released by the word
// that carries pixel p + 4*(frame_width+1): after a frame, send that many drain words (or the
// next frame) to push its tail out. Geometry is clamped to 3..MAX_WIDTH by 3..MAX_HEIGHT.
module depth_threshold_morph_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dtmf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [dtmf_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dtmf_pkg::DepthBits-1:0]   depth_sample_i,
  input  logic                             drain_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             mask_pixel_o,
  output logic                             last_of_frame_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [dtmf_pkg::GeoBits-1:0]   frame_width_q, frame_height_q;
  logic [dtmf_pkg::DepthBits-1:0] depth_cutoff_q;
  logic [WW-1:0] geo_w;
  logic [HW-1:0] geo_h;

  logic en;
  dtmf_pkg::tok_t in_q;
  dtmf_pkg::tok_t slot [dtmf_pkg::NumStages+1];
  logic           stage_last [dtmf_pkg::NumStages];

  logic       fifo_mask_q [2];
  logic       fifo_last_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= dtmf_pkg::FrameWidthReset;
      frame_height_q <= dtmf_pkg::FrameHeightReset;
      depth_cutoff_q <= dtmf_pkg::DepthCutoffReset;
    end else if (cfg_valid_i) begin
      unique case (dtmf_pkg::cfg_idx_e'(cfg_index_i))
        dtmf_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[dtmf_pkg::GeoBits-1:0];
        dtmf_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[dtmf_pkg::GeoBits-1:0];
        dtmf_pkg::CFG_DEPTH_CUTOFF: depth_cutoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q < dtmf_pkg::GeoMin) begin
      geo_w = WW'(dtmf_pkg::GeoMin);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      geo_w = WW'(MAX_WIDTH);
    end else begin
      geo_w = WW'(frame_width_q);
    end
    if (frame_height_q < dtmf_pkg::GeoMin) begin
      geo_h = HW'(dtmf_pkg::GeoMin);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      geo_h = HW'(MAX_HEIGHT);
    end else begin
      geo_h = HW'(frame_height_q);
    end
  end

  // the whole chain moves together while the result queue has room
  assign en         = cnt_q != 2'd2;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q.tok <= in_valid_i;
      in_q.vld <= ~drain_i;
      in_q.px  <= depth_sample_i >= depth_cutoff_q;
    end
  end

  assign slot[0] = in_q;

  for (genvar s = 0; s < dtmf_pkg::NumStages; s++) begin : g_stage
    dtmf_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .ERODE     (dtmf_pkg::StageErodes[s])
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .geo_w_i(geo_w),
      .geo_h_i(geo_h),
      .in_i   (slot[s]),
      .out_o  (slot[s+1]),
      .last_o (stage_last[s])
    );
  end

  assign push = en && slot[dtmf_pkg::NumStages].tok && slot[dtmf_pkg::NumStages].vld;
  assign pop  = (cnt_q != 2'd0) && out_ready_i;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mask_q[wr_q] <= slot[dtmf_pkg::NumStages].px;
      fifo_last_q[wr_q] <= stage_last[dtmf_pkg::NumStages-1];
    end
  end

  assign out_valid_o     = cnt_q != 2'd0;
  assign mask_pixel_o    = fifo_mask_q[rd_q];
  assign last_of_frame_o = fifo_last_q[rd_q];

endmodule

// ----- design/dtmf_checker.sv -----
module dtmf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic mask_pixel_i,
  input logic last_of_frame_i
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mask_pixel_i) &&
                                    $stable(last_of_frame_i))
    else $error("result word changed while stalled");

  // input only backs up behind waiting results
  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  // taking a result frees room for the next input word
  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i)
    else $error("input still stalled after a result was taken");

endmodule

bind depth_threshold_morph_filter dtmf_checker u_dtmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .mask_pixel_i   (mask_pixel_o),
  .last_of_frame_i(last_of_frame_o)
);
